// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mrp_pkg.sv =====
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int unsigned RX_W    = 8;
    localparam int unsigned CH_W    = 5;
    localparam int unsigned DATA_W  = 7;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned M_TDATA_W = 40;

    // Register indexes of the configuration port
    localparam logic CFG_THRU_MODE     = 1'b0;
    localparam logic CFG_INPUT_CHANNEL = 1'b1;

    // Thru modes
    localparam logic [MODE_W-1:0] THRU_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] THRU_FULL = 2'd1;
    localparam logic [MODE_W-1:0] THRU_SAME = 2'd2;
    localparam logic [MODE_W-1:0] THRU_DIFF = 2'd3;

    // Status byte codes
    localparam logic [7:0] STATUS_REALTIME  = 8'hF8;
    localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
    localparam logic [7:0] STATUS_SONG_POS  = 8'hF2;
    localparam logic [7:0] STATUS_TIMECODE  = 8'hF1;
    localparam logic [7:0] STATUS_SONG_SEL  = 8'hF3;
    localparam logic [3:0] NIB_PROG_CHANGE  = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESS   = 4'hD;
    localparam logic [3:0] NIB_SYSTEM       = 4'hF;

    localparam logic KIND_THRU = 1'b0;
    localparam logic KIND_MSG  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } mrp_state_t;

    typedef struct packed {
        logic accept;
        logic emit;
    } mrp_cmd_t;

    typedef struct packed {
        logic finish;
        logic emit_last;
        logic out_free;
    } mrp_status_t;

    // Number of data bytes that follow a status byte
    function automatic logic [1:0] data_length(input logic [7:0] status);
        logic [1:0] len;
        if ((status & STATUS_REALTIME) == STATUS_REALTIME)
            len = 2'd0;
        else if (status[7:4] == NIB_SYSTEM)
        begin
            if (status == STATUS_SONG_POS)
                len = 2'd2;
            else if (status == STATUS_TIMECODE || status == STATUS_SONG_SEL)
                len = 2'd1;
            else
                len = 2'd0;
        end
        else if (status[7:4] == NIB_PROG_CHANGE || status[7:4] == NIB_CHAN_PRESS)
            len = 2'd1;
        else
            len = 2'd2;
        return len;
    endfunction

endpackage

// ===== rtl/mrp_ctrl.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mrp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mrp_pkg::mrp_status_t status,
    output mrp_pkg::mrp_cmd_t    cmd
);
    import mrp_pkg::*;

    mrp_state_t state_reg;
    mrp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && status.finish)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    `ASSERT_NEXT(a_finish_enters_emit, cmd.accept && status.finish, state_reg == ST_EMIT)
    `ASSERT_NEXT(a_last_leaves_emit, cmd.emit && status.emit_last, state_reg == ST_IDLE)
    `ASSERT_ALWAYS(a_no_accept_and_emit, !(cmd.accept && cmd.emit))

endmodule

// ===== rtl/mrp_datapath.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mrp_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic                          cfg_index,
    input  logic [mrp_pkg::CFG_W-1:0]     cfg_data,
    input  logic [mrp_pkg::RX_W-1:0]      rx_byte,
    input  logic                          line_error,
    input  mrp_pkg::mrp_cmd_t             cmd,
    output mrp_pkg::mrp_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mrp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);
    import mrp_pkg::*;

    // Configuration
    logic [MODE_W-1:0] thru_mode_reg;
    logic [CH_W-1:0]   input_channel_reg;

    // Parse state
    logic [7:0] msg0_reg, msg0_next;
    logic [7:0] msg1_reg, msg1_next;
    logic [7:0] msg2_reg, msg2_next;
    logic [1:0] byte_count_reg, byte_count_next;
    logic [1:0] bytes_pending_reg, bytes_pending_next;
    logic [1:0] fin_count_reg, fin_count_next;
    logic [1:0] idx_reg, idx_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg;
    logic [7:0]        out_thru_reg;
    logic [7:0]        out_op_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [DATA_W-1:0] out_d1_reg;
    logic [DATA_W-1:0] out_d2_reg;
    logic              out_last_reg;

    logic [1:0]        status_len;
    logic              finish;
    logic              is_sys;
    logic [7:0]        opcode;
    logic [CH_W-1:0]   channel;
    logic              fwd;
    logic [1:0]        thru_n;
    logic              emit_thru;
    logic [7:0]        thru_sel;
    logic [DATA_W-1:0] d1_sel;
    logic [DATA_W-1:0] d2_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thru_mode_reg     <= THRU_OFF;
            input_channel_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_THRU_MODE:     thru_mode_reg     <= cfg_data[MODE_W-1:0];
                CFG_INPUT_CHANNEL: input_channel_reg <= cfg_data[CH_W-1:0];
                default:           thru_mode_reg     <= thru_mode_reg;
            endcase
        end
    end

    assign status_len = data_length(rx_byte);

    // An error-free, non-F0 zero-length status or final data byte completes a message
    always_comb
    begin
        finish = 1'b0;
        if (!line_error && rx_byte != STATUS_SYSEX)
        begin
            if (rx_byte[7])
                finish = (status_len == 2'd0);
            else
                finish = (bytes_pending_reg == 2'd1);
        end
    end

    always_comb
    begin
        msg0_next          = msg0_reg;
        msg1_next          = msg1_reg;
        msg2_next          = msg2_reg;
        byte_count_next    = byte_count_reg;
        bytes_pending_next = bytes_pending_reg;
        fin_count_next     = fin_count_reg;
        idx_next           = idx_reg;
        if (cmd.accept)
        begin
            priority if (line_error)
            begin
                byte_count_next    = 2'd0;
                bytes_pending_next = 2'd0;
            end
            else if (rx_byte == STATUS_SYSEX)
            begin
                bytes_pending_next = 2'd0;
            end
            else if (rx_byte[7])
            begin
                msg0_next          = rx_byte;
                byte_count_next    = 2'd1;
                bytes_pending_next = status_len;
            end
            else if (bytes_pending_reg != 2'd0)
            begin
                if (byte_count_reg != 2'd3)
                begin
                    unique case (byte_count_reg)
                        2'd0:    msg0_next = rx_byte;
                        2'd1:    msg1_next = rx_byte;
                        default: msg2_next = rx_byte;
                    endcase
                    byte_count_next = byte_count_reg + 2'd1;
                end
                bytes_pending_next = bytes_pending_reg - 2'd1;
            end
            if (finish)
            begin
                // Hold the message size for the emit phase, then clear the parse
                fin_count_next     = byte_count_next;
                byte_count_next    = 2'd0;
                bytes_pending_next = 2'd0;
                idx_next           = 2'd0;
            end
        end
        else if (cmd.emit)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= 2'd0;
            bytes_pending_reg <= 2'd0;
            fin_count_reg     <= 2'd0;
            idx_reg           <= 2'd0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            bytes_pending_reg <= bytes_pending_next;
            fin_count_reg     <= fin_count_next;
            idx_reg           <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg0_reg <= msg0_next;
        msg1_reg <= msg1_next;
        msg2_reg <= msg2_next;
    end

    // Decode of the held message
    assign is_sys  = (msg0_reg[7:4] == NIB_SYSTEM);
    assign opcode  = is_sys ? msg0_reg : {msg0_reg[7:4], 4'h0};
    assign channel = is_sys ? '0 : ({1'b0, msg0_reg[3:0]} + 5'd1);

    always_comb
    begin
        unique case (thru_mode_reg)
            THRU_OFF:  fwd = 1'b0;
            THRU_FULL: fwd = 1'b1;
            THRU_SAME: fwd = is_sys || (channel == input_channel_reg);
            THRU_DIFF: fwd = is_sys || (channel != input_channel_reg);
            default:   fwd = 1'b0;
        endcase
    end

    assign thru_n    = fwd ? fin_count_reg : 2'd0;
    assign emit_thru = (idx_reg < thru_n);
    assign d1_sel    = (fin_count_reg > 2'd1) ? msg1_reg[DATA_W-1:0] : '0;
    assign d2_sel    = (fin_count_reg > 2'd2) ? msg2_reg[DATA_W-1:0] : '0;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    thru_sel = msg0_reg;
            2'd1:    thru_sel = msg1_reg;
            default: thru_sel = msg2_reg;
        endcase
    end

    assign status.finish    = finish;
    assign status.emit_last = !emit_thru;
    assign status.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Load one result beat per emit
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (emit_thru)
            begin
                out_kind_reg <= KIND_THRU;
                out_thru_reg <= thru_sel;
                out_op_reg   <= '0;
                out_ch_reg   <= '0;
                out_d1_reg   <= '0;
                out_d2_reg   <= '0;
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_kind_reg <= KIND_MSG;
                out_thru_reg <= '0;
                out_op_reg   <= opcode;
                out_ch_reg   <= channel;
                out_d1_reg   <= d1_sel;
                out_d2_reg   <= d2_sel;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_kind_reg;
    assign m_tlast    = out_last_reg;
    assign m_tdata    = {5'd0, out_d2_reg, out_d1_reg, out_ch_reg, out_op_reg, out_thru_reg};

    `ASSERT_ALWAYS(a_emit_only_when_free, !cmd.emit || !out_valid_reg || m_tready)
    `ASSERT_NEXT(a_finish_clears_parse, cmd.accept && finish,
        byte_count_reg == 2'd0 && bytes_pending_reg == 2'd0 && idx_reg == 2'd0)
    `ASSERT_ALWAYS(a_thru_beat_not_last, !(m_tvalid && m_tuser[0] == KIND_THRU && m_tlast))

endmodule

// ===== rtl/midi_rx_parser_with_thru.sv =====
// MIDI receive parser with thru forwarding. Each accepted byte (s_tdata) with its line-error
// flag (s_tuser) updates the held status byte and data-byte collection. A byte that
// completes a message yields one to four result beats: first the message bytes for thru
// forwarding (tuser 0) when the thru mode and channel filter allow, then one decoded message
// (tuser 1) with opcode, channel and data, marked by tlast. Results leave one beat per cycle
// through a single output register while m_tready does not stall it; the block takes no new
// byte until its last result beat is loaded; after any other byte it is ready. A line error
// clears the parse, F0 stops data collection, and a new status byte drops a partial message.
// Write thru_mode (index 0) and input_channel (index 1) only while the block is idle.
`timescale 1ns / 1ps

module midi_rx_parser_with_thru
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_wen,
    input  logic                          cfg_index,
    input  logic [mrp_pkg::CFG_W-1:0]     cfg_data,
    // received bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mrp_pkg::RX_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  logic [0:0]                    s_tuser,   // [0] line_error
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mrp_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] thru_byte, [15:8] msg_opcode,
                                                     // [20:16] msg_channel, [27:21] msg_data1,
                                                     // [34:28] msg_data2, [39:35] zero
    output logic [0:0]                    m_tuser,   // [0] kind
    output logic                          m_tlast
);
    import mrp_pkg::*;

    mrp_cmd_t    cmd;
    mrp_status_t status;

    mrp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mrp_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (s_tdata),
        .line_error (s_tuser[0]),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
